[rtl/ddc_pkg.sv]
`default_nettype none
package ddc_pkg;

    localparam int DATA_W     = 32;
    localparam int CORR_W     = 31;
    localparam int DIV_STEPS  = CORR_W;
    localparam int STEP_CNT_W = $clog2(DIV_STEPS);

    localparam int HISTORY_DEPTH_DEF = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int STEP_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ZERO_CURRENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_STEP   = 2'd1;

    localparam logic [STEP_W-1:0] DECAY_STEP_RST = 16'd100;
    localparam logic [CORR_W-1:0] MAX31          = {CORR_W{1'b1}};

    localparam logic [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};

endpackage
`default_nettype wire

[rtl/ddc_div.sv]
`default_nettype none
// restoring divider, one quotient bit per cycle
module ddc_div #(
    parameter int DIVISOR_W = 5
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [ddc_pkg::CORR_W-1:0]    dividend,
    input  wire logic [DIVISOR_W-1:0]          divisor,
    output logic                               done,
    output logic [ddc_pkg::CORR_W-1:0]         quotient
);

    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic [ddc_pkg::STEP_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [ddc_pkg::CORR_W-1:0]         quo_reg, quo_next;
    logic [DIVISOR_W-1:0]               rem_reg, rem_next;
    logic [DIVISOR_W-1:0]               dvs_reg, dvs_next;
    logic [DIVISOR_W:0]                 trial;
    logic [DIVISOR_W:0]                 diff;

    assign trial = {rem_reg, quo_reg[ddc_pkg::CORR_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[DIVISOR_W-1:0];
                quo_next = {quo_reg[ddc_pkg::CORR_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIVISOR_W-1:0];
                quo_next = {quo_reg[ddc_pkg::CORR_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ddc_pkg::STEP_CNT_W'(ddc_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

[rtl/ddc_hist.sv]
`default_nettype none
// excess history ring, valid bit per entry so an unwritten entry reads zero
module ddc_hist #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [IDX_W-1:0]              wr_addr,
    input  wire logic [ddc_pkg::CORR_W-1:0]    wr_data,
    input  wire logic                          rd_en,
    input  wire logic [IDX_W-1:0]              rd_addr,
    output logic [ddc_pkg::CORR_W-1:0]         rd_data
);

    logic [ddc_pkg::CORR_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]           vld_reg;
    logic [ddc_pkg::CORR_W-1:0] data_reg;
    logic                       hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = hit_reg ? data_reg : '0;

endmodule
`default_nettype wire

[rtl/detector_drift_correction.sv]
`default_nettype none
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   tdata: sample_current; tuser: warmup_over
// m_*       out  m_tvalid/m_tready   tdata: corrected_current, correction_amount
//                                    tuser: correction_finished
// cfg_*     in   cfg_valid/cfg_ready cfg_index, cfg_data (always ready)
//
// warm-up item: from accept to ready again, the sequencer walks the history entries
//   up to the first zero entry, or all HISTORY_DEPTH entries when no entry is zero;
//   each entry costs one memory read and one check, and each nonzero entry also a
//   pass through the shared restoring divider (31 quotient steps, then done)
// later-phase item: decay on accept, then straight to the output state
// reset clears the history valid bits at once, so no clearing pass is needed
// a finished result sits in the output register while the next item is taken;
//   the sequencer stalls in its last state only if that register is still full
module detector_drift_correction #(
    parameter int HISTORY_DEPTH = ddc_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // input items
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [31:0]                     s_tdata,   // [31:0] sample_current
    input  wire logic                            s_tuser,   // [0] warmup_over
    // result items
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [63:0]                          m_tdata,   // [31:0] corrected_current,
                                                            // [62:32] correction_amount,
                                                            // [63] zero fill
    output logic                                 m_tuser,   // [0] correction_finished
    // register writes
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [ddc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ddc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int IDX_W  = $clog2(HISTORY_DEPTH);
    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int DW     = ddc_pkg::DATA_W;
    localparam int CW     = ddc_pkg::CORR_W;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]                 state_reg, state_next;
    logic [DW-1:0]              zero_reg;
    logic [ddc_pkg::STEP_W-1:0] step_reg;
    logic [IDX_W-1:0]           wpos_reg, wpos_next;
    logic [FILL_W-1:0]          fill_reg, fill_next;
    logic [CW-1:0]              corr_reg, corr_next;
    logic [CW-1:0]              sum_reg, sum_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [DW-1:0]              sample_reg, sample_next;
    logic                       fin_reg, fin_next;
    logic                       ovld_reg, ovld_next;
    logic [DW-1:0]              ocur_reg, ocur_next;
    logic [CW-1:0]              ocorr_reg, ocorr_next;
    logic                       ofin_reg, ofin_next;

    logic                       accept;
    logic                       out_free;
    logic [DW:0]                excess_diff;
    logic [CW-1:0]              excess;
    logic [DW:0]                sub_diff;
    logic [DW-1:0]              corrected;
    logic [CW:0]                sum_add;
    logic                       hist_wr;
    logic                       hist_rd;
    logic [CW-1:0]              hist_data;
    logic                       div_start;
    logic                       div_done;
    logic [CW-1:0]              div_quo;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !ovld_reg || m_tready;

    // excess over zero point, clamped to [0, 2^31-1]
    assign excess_diff = {s_tdata[DW-1], s_tdata} - {zero_reg[DW-1], zero_reg};
    always_comb
    begin
        if (excess_diff[DW])
            excess = '0;
        else if (excess_diff[DW-1])
            excess = ddc_pkg::MAX31;
        else
            excess = excess_diff[CW-1:0];
    end

    // sample minus correction; only the negative side can overflow
    assign sub_diff = {sample_reg[DW-1], sample_reg} - {2'b00, corr_reg};
    always_comb
    begin
        if (sub_diff[DW] != sub_diff[DW-1])
            corrected = sub_diff[DW] ? ddc_pkg::S32_MIN : ddc_pkg::S32_MAX;
        else
            corrected = sub_diff[DW-1:0];
    end

    assign sum_add = {1'b0, sum_reg} + {1'b0, div_quo};

    assign hist_wr   = accept && !s_tuser;
    assign hist_rd   = (state_reg == ST_RD);
    assign div_start = (state_reg == ST_CHK) && (hist_data != '0);

    always_comb
    begin
        state_next  = state_reg;
        wpos_next   = wpos_reg;
        fill_next   = fill_reg;
        corr_next   = corr_reg;
        sum_next    = sum_reg;
        idx_next    = idx_reg;
        sample_next = sample_reg;
        fin_next    = fin_reg;
        ovld_next   = ovld_reg && !m_tready;
        ocur_next   = ocur_reg;
        ocorr_next  = ocorr_reg;
        ofin_next   = ofin_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    sample_next = s_tdata;
                    if (!s_tuser)
                    begin
                        // warm-up: record excess, then rebuild the average
                        if (fill_reg < FILL_W'(HISTORY_DEPTH))
                            fill_next = fill_reg + 1'b1;
                        if (wpos_reg == IDX_W'(HISTORY_DEPTH - 1))
                            wpos_next = '0;
                        else
                            wpos_next = wpos_reg + 1'b1;
                        fin_next   = 1'b0;
                        sum_next   = '0;
                        idx_next   = '0;
                        state_next = ST_RD;
                    end
                    else
                    begin
                        // later phase: decay toward zero
                        fin_next = (corr_reg == '0);
                        if (corr_reg >= CW'(step_reg))
                            corr_next = corr_reg - CW'(step_reg);
                        else
                            corr_next = '0;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_RD:
            begin
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                // walk stops at the first entry that reads zero
                if (hist_data == '0)
                begin
                    corr_next  = sum_reg;
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    sum_next = sum_add[CW] ? ddc_pkg::MAX31 : sum_add[CW-1:0];
                    if (idx_reg == IDX_W'(HISTORY_DEPTH - 1))
                    begin
                        corr_next  = sum_add[CW] ? ddc_pkg::MAX31 : sum_add[CW-1:0];
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_RD;
                    end
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    ovld_next  = 1'b1;
                    ocur_next  = corrected;
                    ocorr_next = corr_reg;
                    ofin_next  = fin_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            zero_reg  <= '0;
            step_reg  <= ddc_pkg::DECAY_STEP_RST;
            wpos_reg  <= '0;
            fill_reg  <= '0;
            corr_reg  <= '0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wpos_reg  <= wpos_next;
            fill_reg  <= fill_next;
            corr_reg  <= corr_next;
            ovld_reg  <= ovld_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    ddc_pkg::REG_ZERO_CURRENT: zero_reg <= cfg_data;
                    ddc_pkg::REG_DECAY_STEP:   step_reg <= cfg_data[ddc_pkg::STEP_W-1:0];
                    default:                   ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg    <= sum_next;
        idx_reg    <= idx_next;
        sample_reg <= sample_next;
        fin_reg    <= fin_next;
        ocur_reg   <= ocur_next;
        ocorr_reg  <= ocorr_next;
        ofin_reg   <= ofin_next;
    end

    ddc_hist #(
        .DEPTH (HISTORY_DEPTH),
        .IDX_W (IDX_W)
    ) u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (hist_wr),
        .wr_addr (wpos_reg),
        .wr_data (excess),
        .rd_en   (hist_rd),
        .rd_addr (idx_reg),
        .rd_data (hist_data)
    );

    // shared divider: entry / fill count
    ddc_div #(
        .DIVISOR_W (FILL_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (hist_data),
        .divisor  (fill_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign m_tvalid = ovld_reg;
    assign m_tdata  = {1'b0, ocorr_reg, ocur_reg};
    assign m_tuser  = ofin_reg;

endmodule
`default_nettype wire
